>>> hdl/sprpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sprpq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 16;
    localparam int ID_BITS_DEF  = 8;

    localparam int STATUS_BITS = 2;

    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/shortest_remaining_priority_queue.sv
// sorted ready queue for a shortest-remaining-time scheduler
// input channel s_*: one request per transfer, s_op selects enqueue or dequeue;
//   an enqueue carries s_task_id and s_remaining_key
// result channel m_*: exactly one result per request, in request order;
//   m_status done, full (enqueue dropped) or empty (dequeue on empty queue),
//   m_out_task_id / m_out_key hold the removed entry on a good dequeue, else zero,
//   m_occupancy is the entry count after the request
// entries live in a row of DEPTH compare-and-shift cells kept in ascending key
//   order; every cell decides its new content in parallel
// the result is registered and is valid in the cycle after the request is accepted
// throughput: one request per cycle while the receiver takes each result;
// when the receiver stalls, the result is held in the output register and no
//   further request is taken until that result leaves
// reset (aresetn low, synchronous) empties the queue and drops any pending
//   result; cell contents are not cleared and no request is taken during reset
`timescale 1ns / 1ps
`default_nettype none

module shortest_remaining_priority_queue #(
    parameter int DEPTH    = sprpq_pkg::DEPTH_DEF,
    parameter int KEY_BITS = sprpq_pkg::KEY_BITS_DEF,
    parameter int ID_BITS  = sprpq_pkg::ID_BITS_DEF,
    parameter int CNT_BITS = $clog2(DEPTH + 1)
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire                                 s_op,
    input  wire  [ID_BITS-1:0]                  s_task_id,
    input  wire  [KEY_BITS-1:0]                 s_remaining_key,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [sprpq_pkg::STATUS_BITS-1:0]   m_status,
    output logic [ID_BITS-1:0]                  m_out_task_id,
    output logic [KEY_BITS-1:0]                 m_out_key,
    output logic [CNT_BITS-1:0]                 m_occupancy
);

    logic                                 accept;
    logic                                 full;
    logic                                 empty;
    sprpq_pkg::cell_ctrl_t                ctrl;

    logic [CNT_BITS-1:0]                  count_reg;
    logic [CNT_BITS-1:0]                  count_next;
    logic                                 m_valid_reg;
    logic [sprpq_pkg::STATUS_BITS-1:0]    status_reg;
    logic [sprpq_pkg::STATUS_BITS-1:0]    status_next;
    logic [ID_BITS-1:0]                   out_id_reg;
    logic [ID_BITS-1:0]                   out_id_next;
    logic [KEY_BITS-1:0]                  out_key_reg;
    logic [KEY_BITS-1:0]                  out_key_next;
    logic [CNT_BITS-1:0]                  occ_reg;

    logic [DEPTH-1:0]                     occupied;
    logic [DEPTH-1:0]                     goes_left;
    logic [KEY_BITS-1:0]                  cell_key [DEPTH];
    logic [ID_BITS-1:0]                   cell_id  [DEPTH];

    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);

    assign ctrl.enq = accept && (s_op == sprpq_pkg::OP_ENQ) && !full;
    assign ctrl.deq = accept && (s_op == sprpq_pkg::OP_DEQ) && !empty;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic                prev_gl;
            logic [KEY_BITS-1:0] prev_k;
            logic [ID_BITS-1:0]  prev_i;
            logic [KEY_BITS-1:0] next_k;
            logic [ID_BITS-1:0]  next_i;

            assign occupied[i] = (CNT_BITS'(i) < count_reg);

            if (i == 0) begin : g_head
                assign prev_gl = 1'b1;
                assign prev_k  = '0;
                assign prev_i  = '0;
            end else begin : g_body
                assign prev_gl = goes_left[i-1];
                assign prev_k  = cell_key[i-1];
                assign prev_i  = cell_id[i-1];
            end

            if (i == DEPTH - 1) begin : g_tail
                assign next_k = '0;
                assign next_i = '0;
            end else begin : g_link
                assign next_k = cell_key[i+1];
                assign next_i = cell_id[i+1];
            end

            sprpq_cell #(
                .KEY_BITS (KEY_BITS),
                .ID_BITS  (ID_BITS)
            ) u_cell (
                .aclk           (aclk),
                .ctrl           (ctrl),
                .occupied       (occupied[i]),
                .new_key        (s_remaining_key),
                .new_id         (s_task_id),
                .prev_goes_left (prev_gl),
                .prev_key       (prev_k),
                .prev_id        (prev_i),
                .next_key       (next_k),
                .next_id        (next_i),
                .goes_left      (goes_left[i]),
                .key            (cell_key[i]),
                .id             (cell_id[i])
            );
        end
    endgenerate

    always_comb begin
        count_next   = count_reg;
        status_next  = sprpq_pkg::ST_DONE;
        out_id_next  = '0;
        out_key_next = '0;
        if (s_op == sprpq_pkg::OP_ENQ) begin
            if (full) begin
                status_next = sprpq_pkg::ST_FULL;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (empty) begin
                status_next = sprpq_pkg::ST_EMPTY;
            end else begin
                count_next   = count_reg - 1'b1;
                out_id_next  = cell_id[0];
                out_key_next = cell_key[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            out_id_reg  <= out_id_next;
            out_key_reg <= out_key_next;
            occ_reg     <= count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_out_task_id = out_id_reg;
    assign m_out_key     = out_key_reg;
    assign m_occupancy   = occ_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("entry count above depth");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= CNT_BITS'(2) |-> cell_key[0] <= cell_key[1])
        else $error("head cells out of key order");

    a_deq_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.deq |=> m_status == sprpq_pkg::ST_DONE
                     && m_occupancy == $past(count_reg) - 1'b1
                     && m_out_key == $past(cell_key[0]))
        else $error("dequeue result does not match head entry");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_op == sprpq_pkg::OP_ENQ && full
        |=> m_status == sprpq_pkg::ST_FULL && $stable(count_reg))
        else $error("enqueue on full queue not dropped");
`endif

endmodule

`default_nettype wire

>>> hdl/sprpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module sprpq_cell #(
    parameter int KEY_BITS = sprpq_pkg::KEY_BITS_DEF,
    parameter int ID_BITS  = sprpq_pkg::ID_BITS_DEF
) (
    input  wire                      aclk,
    input  wire sprpq_pkg::cell_ctrl_t ctrl,
    input  wire                      occupied,
    input  wire  [KEY_BITS-1:0]      new_key,
    input  wire  [ID_BITS-1:0]       new_id,
    input  wire                      prev_goes_left,
    input  wire  [KEY_BITS-1:0]      prev_key,
    input  wire  [ID_BITS-1:0]       prev_id,
    input  wire  [KEY_BITS-1:0]      next_key,
    input  wire  [ID_BITS-1:0]       next_id,
    output logic                     goes_left,
    output logic [KEY_BITS-1:0]      key,
    output logic [ID_BITS-1:0]       id
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [ID_BITS-1:0]  id_reg;
    logic [ID_BITS-1:0]  id_next;

    // held entry stays ahead of an equal key so ties leave in arrival order
    assign goes_left = occupied && (key_reg <= new_key);

    always_comb begin
        key_next = key_reg;
        id_next  = id_reg;
        if (ctrl.enq) begin
            if (!goes_left) begin
                if (prev_goes_left) begin
                    key_next = new_key;
                    id_next  = new_id;
                end else begin
                    key_next = prev_key;
                    id_next  = prev_id;
                end
            end
        end else if (ctrl.deq) begin
            key_next = next_key;
            id_next  = next_id;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    assign key = key_reg;
    assign id  = id_reg;

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH       = sprpq_pkg::DEPTH_DEF;
    localparam int KEY_W       = sprpq_pkg::KEY_BITS_DEF;
    localparam int ID_W        = sprpq_pkg::ID_BITS_DEF;
    localparam int ST_W        = sprpq_pkg::STATUS_BITS;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int N_REQUESTS  = 1350;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [ST_W-1:0]        status;
        logic [ID_W-1:0]        task_id;
        logic [KEY_W-1:0]       key;
        logic [CNT_W-1:0]       occupancy;
    } queue_result_t;

    class ready_queue_board;
        logic [KEY_W-1:0] held_keys [DEPTH];
        logic [ID_W-1:0]  held_ids [DEPTH];
        int               held_count;
        queue_result_t    expected_results [$];
        int               errors;

        function new();
            held_count = 0;
            errors     = 0;
        endfunction

        function void note_request(logic op, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
            queue_result_t r;
            int            pos;
            r = '0;
            if (op == sprpq_pkg::OP_ENQ) begin
                if (held_count == DEPTH) begin
                    r.status = sprpq_pkg::ST_FULL;
                end else begin
                    // ties go behind the entries already held
                    pos = 0;
                    while (pos < held_count && key >= held_keys[pos])
                        pos++;
                    for (int i = held_count; i > pos; i--) begin
                        held_keys[i] = held_keys[i-1];
                        held_ids[i]  = held_ids[i-1];
                    end
                    held_keys[pos] = key;
                    held_ids[pos]  = id;
                    held_count++;
                    r.status = sprpq_pkg::ST_DONE;
                end
            end else if (held_count == 0) begin
                r.status = sprpq_pkg::ST_EMPTY;
            end else begin
                r.status  = sprpq_pkg::ST_DONE;
                r.task_id = held_ids[0];
                r.key     = held_keys[0];
                for (int i = 1; i < held_count; i++) begin
                    held_keys[i-1] = held_keys[i];
                    held_ids[i-1]  = held_ids[i];
                end
                held_count--;
            end
            r.occupancy = CNT_W'(held_count);
            expected_results.push_back(r);
        endfunction

        function void report(string what, int want, int got);
            errors++;
            if (errors <= 10)
                $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
        endfunction

        function void check_result(queue_result_t got);
            queue_result_t want;
            if (expected_results.size() == 0) begin
                report("result with no request outstanding, status", -1, got.status);
                return;
            end
            want = expected_results.pop_front();
            if (got.status != want.status)
                report("status", want.status, got.status);
            if (got.task_id != want.task_id)
                report("task id", want.task_id, got.task_id);
            if (got.key != want.key)
                report("key", want.key, got.key);
            if (got.occupancy != want.occupancy)
                report("occupancy", want.occupancy, got.occupancy);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_op;
    logic [ID_W-1:0]        s_task_id;
    logic [KEY_W-1:0]       s_remaining_key;
    logic                   m_valid;
    logic                   m_ready;
    logic [ST_W-1:0]        m_status;
    logic [ID_W-1:0]        m_out_task_id;
    logic [KEY_W-1:0]       m_out_key;
    logic [CNT_W-1:0]       m_occupancy;

    ready_queue_board sb = new();
    logic             calm;
    logic             hold_off_req;
    int               requests_sent;
    int               cycle_count;

    shortest_remaining_priority_queue u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_task_id       (s_task_id),
        .s_remaining_key (s_remaining_key),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_task_id   (m_out_task_id),
        .m_out_key       (m_out_key),
        .m_occupancy     (m_occupancy)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_request(s_op, s_task_id, s_remaining_key);
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_status, m_out_task_id, m_out_key, m_occupancy});
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return KEY_W'($urandom);
        if (r < 85)
            return KEY_W'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0: return '0;
            1: return KEY_W'(1);
            2: return {{(KEY_W-1){1'b1}}, 1'b0};
            default: return '1;
        endcase
    endfunction

    task automatic send_request(logic op, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_task_id       <= id;
        s_remaining_key <= key;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        requests_sent++;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        m_ready <= 1'b0;
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int enq_pct;
        s_valid         <= 1'b0;
        s_op            <= sprpq_pkg::OP_ENQ;
        s_task_id       <= '0;
        s_remaining_key <= '0;
        aresetn         <= 1'b0;
        calm          = 1'b1;
        hold_off_req  = 1'b0;
        requests_sent = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // dequeue on empty, field extremes, equal keys leave in arrival order
        send_request(sprpq_pkg::OP_DEQ, '1, '1);
        send_request(sprpq_pkg::OP_ENQ, '1, '1);
        send_request(sprpq_pkg::OP_ENQ, '0, '0);
        send_request(sprpq_pkg::OP_ENQ, ID_W'(8'ha5), KEY_W'(16'h5a5a));
        send_request(sprpq_pkg::OP_ENQ, ID_W'(8'h5a), KEY_W'(16'ha5a5));
        send_request(sprpq_pkg::OP_ENQ, ID_W'(1), KEY_W'(16'h5a5a));
        repeat (3) send_request(sprpq_pkg::OP_DEQ, '0, '0);
        // fill up with falling keys, then enqueue on full and dequeue on full
        for (int i = 0; i < DEPTH - 2; i++)
            send_request(sprpq_pkg::OP_ENQ, ID_W'(i + 16), KEY_W'(1000 - 7 * i));
        send_request(sprpq_pkg::OP_ENQ, ID_W'(8'h77), KEY_W'(0));
        send_request(sprpq_pkg::OP_DEQ, ID_W'(8'h3c), KEY_W'(16'hc3c3));

        for (int phase = 0; requests_sent < N_REQUESTS; phase++) begin
            case ($urandom_range(0, 2))
                0: enq_pct = 85;
                1: enq_pct = 50;
                default: enq_pct = 20;
            endcase
            calm = ($urandom_range(0, 3) == 0);
            if (phase == 6) begin
                hold_off_req = 1'b1;
                calm         = 1'b1;
                enq_pct      = 85;
            end
            repeat ($urandom_range(30, 60)) begin
                if ($urandom_range(0, 99) < enq_pct)
                    send_request(sprpq_pkg::OP_ENQ, ID_W'($urandom), pick_key());
                else
                    send_request(sprpq_pkg::OP_DEQ, ID_W'($urandom), KEY_W'($urandom));
            end
        end
        s_valid <= 1'b0;

        while (sb.expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
